/* rtl/core/dad_pkg.sv */
// Shared types, constants and month-length table for the date adder.
`default_nettype none
package dad_pkg;

  localparam int DayW    = 5;
  localparam int MonthW  = 4;
  localparam int YearW   = 14;
  localparam int AddW    = 16;
  localparam int AccW    = 17;   // start day plus add count
  localparam int InDataW  = 40;
  localparam int OutDataW = 24;

  // year / 100 by reciprocal: (year * 5243) >> 19, exact for 14-bit years
  localparam int RecipW     = 13;
  localparam int RecipShift = 19;
  localparam int ProdW      = YearW + RecipW;
  localparam int QuotW      = ProdW - RecipShift;
  localparam int RemW       = 7;
  localparam logic [RecipW-1:0] Recip100 = 13'd5243;
  localparam logic [6:0]        Century  = 7'd100;

  localparam logic [MonthW-1:0] January  = 4'd1;
  localparam logic [MonthW-1:0] February = 4'd2;
  localparam logic [MonthW-1:0] December = 4'd12;
  localparam logic [YearW-1:0]  YearMax  = 14'h3FFF;
  localparam logic [RemW-1:0]   RemLast  = 7'd99;

  typedef struct packed {
    logic load;
    logic mul;
    logic div;
    logic step;
    logic emit;
  } dad_cmd_t;

  typedef struct packed {
    logic more;
  } dad_stat_t;

  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m,
                                                 input logic leap);
    logic [DayW-1:0] d;
    case (m)
      4'd1:    d = 5'd31;
      4'd2:    d = leap ? 5'd29 : 5'd28;
      4'd3:    d = 5'd31;
      4'd4:    d = 5'd30;
      4'd5:    d = 5'd31;
      4'd6:    d = 5'd30;
      4'd7:    d = 5'd31;
      4'd8:    d = 5'd31;
      4'd9:    d = 5'd30;
      4'd10:   d = 5'd31;
      4'd11:   d = 5'd30;
      4'd12:   d = 5'd31;
      default: d = 5'd31;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/date_add_days.sv */
// Top level of the Gregorian date adder: stream ports, controller and datapath.
//
//  channel   dir  beat contents
//  s_axis    in   start date and day count to add
//  m_axis    out  resulting date, one beat per input beat
//
//  An item passes through setup (load, year/100 multiply, remainder), then one
//  month step per month boundary crossed, then the write to the result register.
//  The month loop steps one month per cycle through a single compare/subtract.
//  Reset is synchronous and clears the controller and output valid.
//  A held result stalls the loop only at its last step; input is taken when idle.
`default_nettype none
module date_add_days
  import dad_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // [4:0] start_day, [8:5] start_month, [22:9] start_year, [38:23] days_to_add
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [4:0] result_day, [8:5] result_month, [22:9] result_year
  output logic [OutDataW-1:0]      m_axis_tdata
);

  dad_cmd_t          cmd;
  dad_stat_t         stat;
  logic [DayW-1:0]   result_day;
  logic [MonthW-1:0] result_month;
  logic [YearW-1:0]  result_year;

  dad_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dad_datapath u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .start_day    (s_axis_tdata[4:0]),
    .start_month  (s_axis_tdata[8:5]),
    .start_year   (s_axis_tdata[22:9]),
    .days_to_add  (s_axis_tdata[38:23]),
    .stat         (stat),
    .result_day   (result_day),
    .result_month (result_month),
    .result_year  (result_year)
  );

  assign m_axis_tdata = {1'b0, result_year, result_month, result_day};

endmodule
`default_nettype wire

/* rtl/core/dad_ctrl.sv */
// Controller: sequences load, century split, month steps and result hand-off.
`default_nettype none
module dad_ctrl
  import dad_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire dad_stat_t stat,
  output dad_cmd_t       cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_RUN  = 2'd3;

  logic [1:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div = 1'b1;
        state_next = S_RUN;
      end
      S_RUN: begin
        if (stat.more) begin
          cmd.step = 1'b1;
        end else if (!out_valid || out_ready) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/dad_datapath.sv */
// Datapath: day accumulator, month/year counters, leap tracking, result register.
`default_nettype none
module dad_datapath
  import dad_pkg::*;
(
  input  wire logic                 clk,
  input  wire dad_cmd_t             cmd,
  input  wire logic [DayW-1:0]      start_day,
  input  wire logic [MonthW-1:0]    start_month,
  input  wire logic [YearW-1:0]     start_year,
  input  wire logic [AddW-1:0]      days_to_add,
  output dad_stat_t                 stat,
  output logic [DayW-1:0]           result_day,
  output logic [MonthW-1:0]         result_month,
  output logic [YearW-1:0]          result_year
);

  logic [AccW-1:0]   day;
  logic [MonthW-1:0] month;
  logic [YearW-1:0]  year;
  logic [ProdW-1:0]  prod;
  logic [RemW-1:0]   rem;      // year mod 100
  logic [1:0]        cent;     // (year / 100) mod 4

  logic [QuotW-1:0]  quot;
  logic [YearW-1:0]  hundreds;
  logic [YearW-1:0]  rem_full;
  logic              leap;
  logic [DayW-1:0]   len;
  logic [MonthW-1:0] month_in;

  assign quot     = prod[ProdW-1:RecipShift];
  assign hundreds = {{(YearW-QuotW){1'b0}}, quot} * {{(YearW-RemW){1'b0}}, Century};
  assign rem_full = year - hundreds;
  assign leap     = (year[1:0] == 2'b00) && ((rem != '0) || (cent == 2'b00));
  assign len      = month_days(month, leap);
  assign stat.more = day > {{(AccW-DayW){1'b0}}, len};
  assign month_in = (start_month < January || start_month > December) ? January
                                                                       : start_month;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      day   <= {{(AccW-DayW){1'b0}}, start_day} + {{(AccW-AddW){1'b0}}, days_to_add};
      month <= month_in;
      year  <= start_year;
    end
    if (cmd.mul) begin
      prod <= {{RecipW{1'b0}}, year} * {{YearW{1'b0}}, Recip100};
    end
    if (cmd.div) begin
      rem  <= rem_full[RemW-1:0];
      cent <= quot[1:0];
    end
    if (cmd.step) begin
      day <= day - {{(AccW-DayW){1'b0}}, len};
      if (month == December) begin
        month <= January;
        year  <= year + 1'b1;
        if (year == YearMax) begin
          rem  <= '0;
          cent <= '0;
        end else if (rem == RemLast) begin
          rem  <= '0;
          cent <= cent + 1'b1;
        end else begin
          rem <= rem + 1'b1;
        end
      end else begin
        month <= month + 1'b1;
      end
    end
    if (cmd.emit) begin
      result_day   <= day[DayW-1:0];
      result_month <= month;
      result_year  <= year;
    end
  end

endmodule
`default_nettype wire
